[rtl/core/htfs_pkg.sv]
// ----------------------------------------------------------------------------
// htfs_pkg
// Shared types, character constants and helpers for the hex telemetry frame
// serializer.
// ----------------------------------------------------------------------------
package htfs_pkg;

  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IN_CHANS = 4;

  localparam logic [BYTE_W-1:0] CHAR_START = 8'h40;  // '@'
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [BYTE_W-1:0] CHAR_END   = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;  // 'A'

  typedef struct packed {
    logic [VALUE_W-1:0] value_0;
    logic [VALUE_W-1:0] value_1;
    logic [VALUE_W-1:0] value_2;
    logic [VALUE_W-1:0] value_3;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_end;
  } tx_t;

  // Uppercase ASCII for one nibble.
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib <= 4'd9) begin
      r = CHAR_ZERO + {4'd0, nib};
    end else begin
      r = CHAR_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

[rtl/core/hex_telemetry_frame_serializer.sv]
// ----------------------------------------------------------------------------
// hex_telemetry_frame_serializer
// Turns a request of sensor values into an ASCII telemetry frame, one byte
// per output transaction.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid, req_ready, req_data): one transaction carries
//   four 16-bit sensor values. Up to two requests wait in a queue ahead of
//   the sequencer, so the sender is only held off when both entries are full.
//   Transmit channel (tx_valid, tx_ready, tx_data): one transaction per frame
//   byte. A frame is '@', four uppercase hex digits and a space for each
//   channel, a two-digit XOR checksum of the preceding bytes, and '*', which
//   carries frame_end. That is 5*NUM_CHANNELS+4 bytes, 24 at the default.
//   A request arriving at an idle block is written into the queue; the
//   sequencer then pops it and registers its '@' into the output stage,
//   and each further byte is registered as the one before it is taken.
//   Throughput: one byte per cycle while tx_ready stays high, set by the
//   single sequencer that walks the frame byte by byte.
//   Frames follow one another back to back.
//   Reset empties the request queue, returns the sequencer to idle and
//   drops tx_valid. When the receiver stalls, the output register holds
//   its byte and the sequencer waits; the queue keeps taking requests.
// ----------------------------------------------------------------------------
module hex_telemetry_frame_serializer #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  htfs_pkg::req_t req_data,
  output logic           tx_valid,
  input  logic           tx_ready,
  output htfs_pkg::tx_t  tx_data
);

  // Queue handshake between the front end and the sequencer.
  logic           q_valid;
  logic           q_pop;
  htfs_pkg::req_t q_data;

  // The front end only captures requests; all framing is done behind it.
  htfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  // The sequencer pops a request as it sends the opening '@', so the next
  // frame can begin the cycle after the closing '*' of the previous one.
  htfs_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .tx_valid (tx_valid),
    .tx_ready (tx_ready),
    .tx_data  (tx_data)
  );

endmodule

[rtl/core/htfs_front.sv]
// ----------------------------------------------------------------------------
// htfs_front
// Request front end: accepts frame requests and holds them in a two-entry
// queue until the serializer takes them.
// ----------------------------------------------------------------------------
module htfs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  htfs_pkg::req_t req_data,
  output logic           q_valid,
  input  logic           q_pop,
  output htfs_pkg::req_t q_data
);

  htfs_pkg::req_t store [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign req_ready = (count != 2'd2);
  assign q_valid   = (count != 2'd0);
  assign q_data    = store[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/htfs_back.sv]
// ----------------------------------------------------------------------------
// htfs_back
// Frame sequencer: takes a queued request and emits its frame one byte per
// cycle into a registered output stage, stalling while the receiver holds off.
// ----------------------------------------------------------------------------
module htfs_back #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  htfs_pkg::req_t q_data,
  output logic           tx_valid,
  input  logic           tx_ready,
  output htfs_pkg::tx_t  tx_data
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_CK_HI = 3'd2;
  localparam logic [2:0] PH_CK_LO = 3'd3;
  localparam logic [2:0] PH_END   = 3'd4;

  localparam logic [2:0] DIG_SPACE = 3'd4;

  logic [htfs_pkg::VALUE_W-1:0] held_values [NUM_CHANNELS];
  logic [2:0]                   phase;
  logic [2:0]                   phase_next;
  logic [CH_W-1:0]              ch;
  logic [CH_W-1:0]              ch_next;
  logic [2:0]                   dig;
  logic [2:0]                   dig_next;
  logic [htfs_pkg::BYTE_W-1:0]  running_xor;
  logic [htfs_pkg::BYTE_W-1:0]  running_xor_next;
  logic                         advance;
  logic                         emit;
  logic                         load;
  htfs_pkg::tx_t                byte_out;
  logic [htfs_pkg::VALUE_W-1:0] cur_value;
  logic [3:0]                   nibble;

  assign advance   = !tx_valid || tx_ready;
  assign cur_value = held_values[ch];
  assign nibble    = 4'(cur_value >> {2'd3 - dig[1:0], 2'b00});
  assign q_pop     = load;

  always_comb begin
    phase_next       = phase;
    ch_next          = ch;
    dig_next         = dig;
    running_xor_next = running_xor;
    emit             = 1'b0;
    load             = 1'b0;
    byte_out         = '0;
    if (advance) begin
      unique case (phase)
        PH_IDLE: begin
          if (q_valid) begin
            load             = 1'b1;
            emit             = 1'b1;
            byte_out.tx_byte = htfs_pkg::CHAR_START;
            running_xor_next = htfs_pkg::CHAR_START;
            ch_next          = '0;
            dig_next         = 3'd0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          if (dig == DIG_SPACE) begin
            byte_out.tx_byte = htfs_pkg::CHAR_SPACE;
            dig_next         = 3'd0;
            if (ch == LAST_CH) begin
              phase_next = PH_CK_HI;
            end else begin
              ch_next = ch + CH_W'(1);
            end
          end else begin
            byte_out.tx_byte = htfs_pkg::hex_digit(nibble);
            dig_next         = dig + 3'd1;
          end
          running_xor_next = running_xor ^ byte_out.tx_byte;
        end
        PH_CK_HI: begin
          emit             = 1'b1;
          byte_out.tx_byte = htfs_pkg::hex_digit(running_xor[7:4]);
          phase_next       = PH_CK_LO;
        end
        PH_CK_LO: begin
          emit             = 1'b1;
          byte_out.tx_byte = htfs_pkg::hex_digit(running_xor[3:0]);
          phase_next       = PH_END;
        end
        PH_END: begin
          emit               = 1'b1;
          byte_out.tx_byte   = htfs_pkg::CHAR_END;
          byte_out.frame_end = 1'b1;
          phase_next         = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Channels above the four request fields are sent as zero.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        case (i)
          0:       held_values[i] <= q_data.value_0;
          1:       held_values[i] <= q_data.value_1;
          2:       held_values[i] <= q_data.value_2;
          3:       held_values[i] <= q_data.value_3;
          default: held_values[i] <= '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_data <= byte_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      ch          <= '0;
      dig         <= 3'd0;
      running_xor <= '0;
      tx_valid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      ch          <= ch_next;
      dig         <= dig_next;
      running_xor <= running_xor_next;
      if (advance) begin
        tx_valid <= emit;
      end
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for hex_telemetry_frame_serializer
// Drives frame requests through the request channel and checks every byte
// that leaves the transmit channel against a frame built here from the same
// request. A short directed set covers the extreme values and every hex
// digit. Three random phases follow, each with a different idling pattern on
// the two sides. The sender waits for each phase to drain before the next.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_CHANNELS = 4;
  localparam int unsigned RESET_CYCLES   = 8;
  // Cycles allowed after the last expected byte for anything stray to show.
  localparam int unsigned TAIL_CYCLES    = 30;
  // Consecutive cycles with no transaction on either side before giving up.
  localparam int unsigned STALL_LIMIT    = 2000;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  htfs_pkg::req_t req_data  = '0;
  logic           tx_valid;
  logic           tx_ready  = 1'b0;
  htfs_pkg::tx_t  tx_data;

  // Requests waiting to be offered, and frame bytes still owed by the block.
  htfs_pkg::req_t pending_reqs[$];
  htfs_pkg::tx_t  owed_chars[$];
  htfs_pkg::tx_t  oldest_char;

  int unsigned sender_idle_pct   = 22;
  int unsigned receiver_idle_pct = 47;
  logic        req_taken         = 1'b0;
  int unsigned quiet_cycles      = 0;
  int unsigned mismatches        = 0;

  hex_telemetry_frame_serializer #(
    .NUM_CHANNELS(FRAME_CHANNELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .tx_valid (tx_valid),
    .tx_ready (tx_ready),
    .tx_data  (tx_data)
  );

  // 4 ns clock: low for half a period, then high.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Uppercase ASCII for one nibble, taken by position from a digit string.
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[nib];
  endfunction

  // Builds the complete frame for one accepted request and appends it to the
  // bytes owed. The checksum covers everything from the '@' up to and
  // including the final space; only the '*' carries frame_end.
  function automatic void predict_frame(input htfs_pkg::req_t r);
    logic [15:0]   vals[FRAME_CHANNELS];
    logic [7:0]    body[$];
    logic [7:0]    checksum;
    htfs_pkg::tx_t t;
    int            ch;
    int            d;
    for (ch = 0; ch < FRAME_CHANNELS; ch++) begin
      vals[ch] = '0;
    end
    // Channels beyond the four request fields would be sent as zero.
    vals[0] = r.value_0;
    vals[1] = r.value_1;
    vals[2] = r.value_2;
    vals[3] = r.value_3;
    body.push_back(htfs_pkg::CHAR_START);
    for (ch = 0; ch < FRAME_CHANNELS; ch++) begin
      for (d = 3; d >= 0; d--) begin
        body.push_back(nibble_char(vals[ch][4*d +: 4]));
      end
      body.push_back(htfs_pkg::CHAR_SPACE);
    end
    checksum = '0;
    foreach (body[i]) begin
      checksum ^= body[i];
    end
    body.push_back(nibble_char(checksum[7:4]));
    body.push_back(nibble_char(checksum[3:0]));
    foreach (body[i]) begin
      t.tx_byte   = body[i];
      t.frame_end = 1'b0;
      owed_chars.push_back(t);
    end
    t.tx_byte   = htfs_pkg::CHAR_END;
    t.frame_end = 1'b1;
    owed_chars.push_back(t);
  endfunction

  // A quarter of the random values are made only of the nibbles at the
  // digit/letter boundary and the ends of the range; the rest are uniform.
  function automatic logic [15:0] rand_value();
    logic [3:0]  edge_nibs[4];
    logic [15:0] v;
    int          d;
    edge_nibs = '{4'h0, 4'h9, 4'hA, 4'hF};
    if ($urandom_range(3) == 0) begin
      for (d = 0; d < 4; d++) begin
        v[4*d +: 4] = edge_nibs[$urandom_range(3)];
      end
    end else begin
      v = 16'($urandom_range(65535));
    end
    return v;
  endfunction

  function automatic htfs_pkg::req_t make_req(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] e);
    htfs_pkg::req_t r;
    r.value_0 = a;
    r.value_1 = b;
    r.value_2 = c;
    r.value_3 = e;
    return r;
  endfunction

  // Driver. Inputs change on the falling edge only. A request stays on the
  // channel, unchanged, until the rising edge at which its transaction
  // completes; only then may the next one be offered or valid be lowered.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_ready  <= 1'b0;
    end else begin
      tx_ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (!req_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_data  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Everything is sampled on the rising edge, before the block's
  // own registers move. An accepted request adds its frame to the bytes
  // owed; each transmit transaction is checked against the oldest of them.
  always @(posedge clk) begin
    req_taken <= req_valid && req_ready && !rst;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predict_frame(req_data);
      end
      if (tx_valid && tx_ready) begin
        if (owed_chars.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual byte %h frame_end %b",
                   $time, tx_data.tx_byte, tx_data.frame_end);
          mismatches++;
        end else begin
          oldest_char = owed_chars.pop_front();
          if (tx_data.tx_byte !== oldest_char.tx_byte) begin
            $display("%0t: tx_byte expected %h actual %h",
                     $time, oldest_char.tx_byte, tx_data.tx_byte);
            mismatches++;
          end
          if (tx_data.frame_end !== oldest_char.frame_end) begin
            $display("%0t: frame_end expected %b actual %b",
                     $time, oldest_char.frame_end, tx_data.frame_end);
            mismatches++;
          end
        end
      end
      // Watchdog: any transaction on either side counts as progress.
      if ((req_valid && req_ready) || (tx_valid && tx_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Holds the sender back until everything offered has been accepted and
  // every byte owed has arrived.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || req_valid || owed_chars.size() != 0);
  endtask

  // One random phase with its own idling pattern. Knobs and the queue are
  // touched on the rising edge so the driver never sees them change under it.
  task automatic run_phase(input int unsigned n_reqs, input int unsigned send_pct,
                           input int unsigned recv_pct);
    @(posedge clk);
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    repeat (n_reqs) begin
      pending_reqs.push_back(make_req(rand_value(), rand_value(),
                                      rand_value(), rand_value()));
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed requests: all zeros and all ones, every hex digit in both
    // orders, the 9/A boundary in each nibble position, alternating and
    // walking bit patterns, and the ends of the signed view of a value.
    pending_reqs.push_back(make_req(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(16'h0123, 16'h4567, 16'h89AB, 16'hCDEF));
    pending_reqs.push_back(make_req(16'hFEDC, 16'hBA98, 16'h7654, 16'h3210));
    pending_reqs.push_back(make_req(16'h0009, 16'h000A, 16'h0090, 16'h00A0));
    pending_reqs.push_back(make_req(16'h9999, 16'hAAAA, 16'hA5A5, 16'h5A5A));
    pending_reqs.push_back(make_req(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE));
    pending_reqs.push_back(make_req(16'h1248, 16'h8421, 16'h9A9A, 16'h0000));
    wait_drained();

    // Random phases: slow receiver, slow sender, then both at full rate so
    // that requests queue up and frames follow one another back to back.
    run_phase(37, 22, 47);
    run_phase(37, 47, 22);
    run_phase(36, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[hex_telemetry_frame_serializer.f]
rtl/core/htfs_pkg.sv
rtl/core/htfs_front.sv
rtl/core/htfs_back.sv
rtl/core/hex_telemetry_frame_serializer.sv
tb/tb_top.sv
